// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CHK_IMPLY(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CHK_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/i2c_pkg.sv =====
// Shared types, constants and the divider step for the im2col index generator.
package i2c_pkg;

  localparam int DIM_BITS    = 12;
  localparam int KERNEL_BITS = 8;
  localparam logic [16:0] DIM_MAX = 17'(1 << DIM_BITS);
  localparam logic [7:0]  KMASK   = 8'((1 << KERNEL_BITS) - 1);

  localparam int PADDR_W = 5;

  localparam logic [2:0] REG_KERNEL  = 3'd0;
  localparam logic [2:0] REG_STRIDE  = 3'd1;
  localparam logic [2:0] REG_DIL     = 3'd2;
  localparam logic [2:0] REG_PAD     = 3'd3;
  localparam logic [2:0] REG_HEIGHT  = 3'd4;
  localparam logic [2:0] REG_WIDTH   = 3'd5;
  localparam logic [2:0] REG_CHANS   = 3'd6;
  localparam logic [2:0] REG_LAYOUT  = 3'd7;

  // Quotient widths: channel index, then kernel row offset.
  localparam int QA_W       = 13;
  localparam int QB_W       = 8;
  localparam int DIV_STEPS  = QA_W + QB_W;
  localparam int STEPS_PER  = 2;
  localparam int DIV_STAGES = (DIV_STEPS + STEPS_PER - 1) / STEPS_PER;

  typedef struct packed {
    logic        busy;
    logic        err;
    logic        layout_nchw;
    logic [7:0]  kh;
    logic [7:0]  kw;
    logic [7:0]  sh;
    logic [7:0]  sw;
    logic [7:0]  dh;
    logic [7:0]  dw;
    logic [7:0]  ph;
    logic [7:0]  pw;
    logic [12:0] height;
    logic [12:0] width;
    logic [12:0] chans;
    logic [15:0] kk;
    logic [28:0] plane;
    logic [13:0] oh;
    logic [13:0] ow;
    logic [27:0] ohow;
  } cfg_t;

  typedef struct packed {
    logic [27:0]     crow;
    logic [12:0]     orow;
    logic [12:0]     ocol;
    logic            oor;
    logic            err;
    logic [27:0]     rem;
    logic [QA_W-1:0] qa;
    logic [QB_W-1:0] qb;
  } dv_t;

  // One restoring step: first by kh*kw for the channel, then by kw for the kernel row.
  function automatic dv_t div_step(dv_t d, int step, logic [15:0] kk, logic [7:0] kw);
    dv_t         r;
    logic [28:0] dvs;
    int          i;
    r   = d;
    dvs = '0;
    i   = 0;
    if (step < QA_W) begin
      i   = QA_W - 1 - step;
      dvs = 29'(kk) << i;
      if ({1'b0, d.rem} >= dvs) begin
        r.rem = d.rem - dvs[27:0];
        r.qa  = d.qa | (QA_W'(1) << i);
      end
    end else if (step < DIV_STEPS) begin
      i   = DIV_STEPS - 1 - step;
      dvs = 29'(kw) << i;
      if ({1'b0, d.rem} >= dvs) begin
        r.rem = d.rem - dvs[27:0];
        r.qb  = d.qb | (QB_W'(1) << i);
      end
    end
    return r;
  endfunction

endpackage

// ===== design/i2c_chan_if.sv =====
// Valid/ready channel interfaces for coordinates in and indices out.
interface i2c_in_if;
  logic        valid;
  logic        ready;
  logic [27:0] column_row;
  logic [12:0] out_row;
  logic [12:0] out_col;
  modport source (output valid, column_row, out_row, out_col, input ready);
  modport sink   (input valid, column_row, out_row, out_col, output ready);
endinterface

interface i2c_out_if;
  logic        valid;
  logic        ready;
  logic [35:0] source_index;
  logic [53:0] dest_index;
  logic        is_padding;
  logic        out_of_range;
  logic        config_error;
  modport source (output valid, source_index, dest_index, is_padding, out_of_range,
                  config_error, input ready);
  modport sink   (input valid, source_index, dest_index, is_padding, out_of_range,
                  config_error, output ready);
endinterface

// ===== design/i2c_cfg.sv =====
// Register file and sequencer for the output extents and plane sizes.
module i2c_cfg import i2c_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output cfg_t               cfg
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_EXT  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;

  logic [15:0] kernel_r, stride_r, dil_r, pad_r;
  logic [12:0] height_r, width_r, chans_r;
  logic        layout_r;
  logic [2:0]  state_r, state_nxt;
  logic [3:0]  cnt_r;
  logic [13:0] ah_r, aw_r;
  logic [7:0]  rh_r, rw_r;
  logic        emph_r, empw_r, ebase_r, err_r;
  logic [15:0] kk_r;
  logic [28:0] plane_r;
  logic [13:0] oh_r, ow_r;
  logic [27:0] ohow_r;

  logic        wr;
  logic [2:0]  idx;
  logic [7:0]  kh, kw;
  logic [13:0] spanh, spanw;
  logic [16:0] reachh, reachw;
  logic        ebase;
  logic [8:0]  th, tw;
  logic        qh, qw;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[4:2];
  assign kh  = kernel_r[15:8] & KMASK;
  assign kw  = kernel_r[7:0] & KMASK;

  always_comb begin
    spanh  = 14'(height_r) + 14'({pad_r[15:8], 1'b0});
    spanw  = 14'(width_r) + 14'({pad_r[7:0], 1'b0});
    reachh = 17'(dil_r[15:8]) * 17'(kh - 8'd1) + 17'd1;
    reachw = 17'(dil_r[7:0]) * 17'(kw - 8'd1) + 17'd1;
    ebase  = kh == '0 || kw == '0 || stride_r[15:8] == '0 || stride_r[7:0] == '0 ||
             dil_r[15:8] == '0 || dil_r[7:0] == '0 || height_r == '0 ||
             width_r == '0 || chans_r == '0 || 17'(height_r) > DIM_MAX ||
             17'(width_r) > DIM_MAX || 17'(chans_r) > DIM_MAX;
    th = {rh_r, ah_r[13]};
    tw = {rw_r, aw_r[13]};
    qh = th >= {1'b0, stride_r[15:8]};
    qw = tw >= {1'b0, stride_r[7:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r <= 16'h0101;
      stride_r <= 16'h0101;
      dil_r    <= 16'h0101;
      pad_r    <= '0;
      height_r <= 13'd1;
      width_r  <= 13'd1;
      chans_r  <= 13'd1;
      layout_r <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_KERNEL: kernel_r <= pwdata[15:0];
        REG_STRIDE: stride_r <= pwdata[15:0];
        REG_DIL:    dil_r    <= pwdata[15:0];
        REG_PAD:    pad_r    <= pwdata[15:0];
        REG_HEIGHT: height_r <= pwdata[12:0];
        REG_WIDTH:  width_r  <= pwdata[12:0];
        REG_CHANS:  chans_r  <= pwdata[12:0];
        REG_LAYOUT: layout_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: state_nxt = ST_IDLE;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV:  state_nxt = (cnt_r == 4'd13) ? ST_EXT : ST_DIV;
      ST_EXT:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_IDLE;
      default: state_nxt = ST_PREP;
    endcase
    if (wr) state_nxt = ST_PREP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PREP;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_r == ST_DIV) ? cnt_r + 4'd1 : '0;
    end
  end

  // Extent datapath: (span - reach) / stride, one quotient bit per cycle per axis.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_PREP: begin
        emph_r  <= reachh > 17'(spanh);
        empw_r  <= reachw > 17'(spanw);
        ah_r    <= spanh - reachh[13:0];
        aw_r    <= spanw - reachw[13:0];
        rh_r    <= '0;
        rw_r    <= '0;
        kk_r    <= 16'(kh) * 16'(kw);
        ebase_r <= ebase;
      end
      ST_DIV: begin
        rh_r <= qh ? 8'(th - {1'b0, stride_r[15:8]}) : th[7:0];
        rw_r <= qw ? 8'(tw - {1'b0, stride_r[7:0]}) : tw[7:0];
        ah_r <= {ah_r[12:0], qh};
        aw_r <= {aw_r[12:0], qw};
      end
      ST_EXT: begin
        oh_r    <= emph_r ? '0 : ah_r + 14'd1;
        ow_r    <= empw_r ? '0 : aw_r + 14'd1;
        err_r   <= ebase_r || emph_r || empw_r;
        plane_r <= 29'(chans_r) * 29'(kk_r);
      end
      ST_MUL: ohow_r <= 28'(oh_r) * 28'(ow_r);
      default: ;
    endcase
  end

  always_comb begin
    case (idx)
      REG_KERNEL: prdata = 32'(kernel_r);
      REG_STRIDE: prdata = 32'(stride_r);
      REG_DIL:    prdata = 32'(dil_r);
      REG_PAD:    prdata = 32'(pad_r);
      REG_HEIGHT: prdata = 32'(height_r);
      REG_WIDTH:  prdata = 32'(width_r);
      REG_CHANS:  prdata = 32'(chans_r);
      REG_LAYOUT: prdata = 32'(layout_r);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.busy        = state_r != ST_IDLE;
    cfg.err         = err_r;
    cfg.layout_nchw = layout_r;
    cfg.kh          = kh;
    cfg.kw          = kw;
    cfg.sh          = stride_r[15:8];
    cfg.sw          = stride_r[7:0];
    cfg.dh          = dil_r[15:8];
    cfg.dw          = dil_r[7:0];
    cfg.ph          = pad_r[15:8];
    cfg.pw          = pad_r[7:0];
    cfg.height      = height_r;
    cfg.width       = width_r;
    cfg.chans       = chans_r;
    cfg.kk          = kk_r;
    cfg.plane       = plane_r;
    cfg.oh          = oh_r;
    cfg.ow          = ow_r;
    cfg.ohow        = ohow_r;
  end

endmodule

// ===== design/i2c_pipe.sv =====
// Index pipeline: split column row by division, then position and index arithmetic.
module i2c_pipe import i2c_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  i2c_in_if.sink    in_chan,
  i2c_out_if.source out_chan
);

  dv_t         dv_r   [DIV_STAGES+1];
  dv_t         dv_nxt [DIV_STAGES+1];
  logic        dv_v_r [DIV_STAGES+1];
  logic        dv_rdy [DIV_STAGES+1];

  // M1
  logic        m1_v_r, m1_oor_r, m1_err_r;
  logic [21:0] m1_hpos_r, m1_wpos_r;
  logic [26:0] m1_pos_r;
  logic [12:0] m1_ocol_r, m1_cim_r;
  logic [27:0] m1_crow_r;
  // M2
  logic        m2_v_r, m2_oor_r, m2_err_r, m2_in_r;
  logic [12:0] m2_hu_r, m2_wu_r, m2_cim_r;
  logic [26:0] m2_posn_r;
  logic [27:0] m2_crow_r;
  // M3
  logic        m3_v_r, m3_oor_r, m3_err_r, m3_in_r;
  logic [55:0] m3_dprod_r;
  logic [25:0] m3_s1_r;
  logic [12:0] m3_hu_r, m3_wu_r, m3_cim_r;
  logic [26:0] m3_posn_r;
  logic [27:0] m3_crow_r;
  // M4
  logic        m4_v_r, m4_oor_r, m4_err_r, m4_in_r;
  logic [53:0] m4_dst_r;
  logic [25:0] m4_s2_r;
  logic [12:0] m4_add_r;
  // output
  logic        o_v_r, o_pad_r, o_oor_r, o_err_r;
  logic [35:0] o_src_r;
  logic [53:0] o_dst_r;

  logic        rdy_m1, rdy_m2, rdy_m3, rdy_m4, rdy_o, acc;
  dv_t         ent;
  dv_t         dq;
  logic [22:0] him, wim;
  logic        in_img;
  logic [38:0] sfull;

  assign rdy_o  = !o_v_r || out_chan.ready;
  assign rdy_m4 = !m4_v_r || rdy_o;
  assign rdy_m3 = !m3_v_r || rdy_m4;
  assign rdy_m2 = !m2_v_r || rdy_m3;
  assign rdy_m1 = !m1_v_r || rdy_m2;

  always_comb begin
    dv_rdy[DIV_STAGES] = !dv_v_r[DIV_STAGES] || rdy_m1;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      dv_rdy[k] = !dv_v_r[k] || dv_rdy[k+1];
    end
  end

  assign in_chan.ready = dv_rdy[0] && !cfg.busy;
  assign acc = in_chan.valid && in_chan.ready;

  always_comb begin
    ent.crow = in_chan.column_row;
    ent.orow = in_chan.out_row;
    ent.ocol = in_chan.out_col;
    ent.oor  = {1'b0, in_chan.column_row} >= cfg.plane ||
               {1'b0, in_chan.out_row} >= cfg.oh || {1'b0, in_chan.out_col} >= cfg.ow;
    ent.err  = cfg.err;
    ent.rem  = in_chan.column_row;
    ent.qa   = '0;
    ent.qb   = '0;
    dv_nxt[0] = ent;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      dv_nxt[k] = dv_r[k-1];
      for (int s = 0; s < STEPS_PER; s++) begin
        dv_nxt[k] = div_step(dv_nxt[k], (k - 1) * STEPS_PER + s, cfg.kk, cfg.kw);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STAGES; k++) dv_v_r[k] <= 1'b0;
    end else begin
      if (dv_rdy[0]) dv_v_r[0] <= acc;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        if (dv_rdy[k]) dv_v_r[k] <= dv_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= DIV_STAGES; k++) begin
      if (dv_rdy[k]) dv_r[k] <= dv_nxt[k];
    end
  end

  assign dq = dv_r[DIV_STAGES];

  always_comb begin
    him    = {1'b0, m1_hpos_r} - 23'(cfg.ph);
    wim    = {1'b0, m1_wpos_r} - 23'(cfg.pw);
    in_img = !him[22] && !wim[22] && him[21:0] < 22'(cfg.height) &&
             wim[21:0] < 22'(cfg.width);
    sfull  = 39'(m4_s2_r) * 39'(cfg.layout_nchw ? cfg.width : cfg.chans) + 39'(m4_add_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
      m4_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (rdy_m1) m1_v_r <= dv_v_r[DIV_STAGES];
      if (rdy_m2) m2_v_r <= m1_v_r;
      if (rdy_m3) m3_v_r <= m2_v_r;
      if (rdy_m4) m4_v_r <= m3_v_r;
      if (rdy_o)  o_v_r  <= m4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m1) begin
      m1_hpos_r <= 22'(dq.orow) * 22'(cfg.sh) + 22'(dq.qb) * 22'(cfg.dh);
      m1_wpos_r <= 22'(dq.ocol) * 22'(cfg.sw) + 22'(dq.rem[7:0]) * 22'(cfg.dw);
      m1_pos_r  <= 27'(dq.orow) * 27'(cfg.ow);
      m1_ocol_r <= dq.ocol;
      m1_cim_r  <= dq.qa;
      m1_crow_r <= dq.crow;
      m1_oor_r  <= dq.oor;
      m1_err_r  <= dq.err;
    end
    if (rdy_m2) begin
      m2_hu_r   <= him[12:0];
      m2_wu_r   <= wim[12:0];
      m2_in_r   <= in_img;
      m2_posn_r <= m1_pos_r + 27'(m1_ocol_r);
      m2_cim_r  <= m1_cim_r;
      m2_crow_r <= m1_crow_r;
      m2_oor_r  <= m1_oor_r;
      m2_err_r  <= m1_err_r;
    end
    if (rdy_m3) begin
      m3_dprod_r <= cfg.layout_nchw ? 56'(m2_crow_r) * 56'(cfg.ohow)
                                    : 56'(m2_posn_r) * 56'(cfg.plane);
      m3_s1_r    <= cfg.layout_nchw ? 26'(m2_cim_r) * 26'(cfg.height)
                                    : 26'(m2_hu_r) * 26'(cfg.width);
      m3_hu_r    <= m2_hu_r;
      m3_wu_r    <= m2_wu_r;
      m3_cim_r   <= m2_cim_r;
      m3_posn_r  <= m2_posn_r;
      m3_crow_r  <= m2_crow_r;
      m3_in_r    <= m2_in_r;
      m3_oor_r   <= m2_oor_r;
      m3_err_r   <= m2_err_r;
    end
    if (rdy_m4) begin
      m4_dst_r <= m3_dprod_r[53:0] +
                  (cfg.layout_nchw ? 54'(m3_posn_r) : 54'(m3_crow_r));
      m4_s2_r  <= m3_s1_r + 26'(cfg.layout_nchw ? m3_hu_r : m3_wu_r);
      m4_add_r <= cfg.layout_nchw ? m3_wu_r : m3_cim_r;
      m4_in_r  <= m3_in_r;
      m4_oor_r <= m3_oor_r;
      m4_err_r <= m3_err_r;
    end
    if (rdy_o) begin
      // Error wins over range, range wins over padding.
      o_err_r <= m4_err_r;
      o_oor_r <= !m4_err_r && m4_oor_r;
      o_pad_r <= !m4_err_r && !m4_oor_r && !m4_in_r;
      o_dst_r <= (m4_err_r || m4_oor_r) ? '0 : m4_dst_r;
      o_src_r <= (m4_err_r || m4_oor_r || !m4_in_r) ? '0 : sfull[35:0];
    end
  end

  assign out_chan.valid        = o_v_r;
  assign out_chan.source_index = o_src_r;
  assign out_chan.dest_index   = o_dst_r;
  assign out_chan.is_padding   = o_pad_r;
  assign out_chan.out_of_range = o_oor_r;
  assign out_chan.config_error = o_err_r;

endmodule

// ===== design/im2col_index_generator_top.sv =====
// Throughput: one coordinate per cycle unless out_chan.ready stalls the pipeline or a
// configuration pass is running; the column-row split is an 11-stage restoring divider
// at two quotient bits per stage, followed by 5 arithmetic stages.
// Reset and every register write start a pass that derives output height,
// width and plane sizes; in_chan.ready stays low during it.
// Reset is synchronous, active low, and restores all register defaults.
`include "assert_macros.svh"
module im2col_index_generator_top import i2c_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  i2c_in_if.sink             in_chan,
  i2c_out_if.source          out_chan,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  cfg_t cfg;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  i2c_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  i2c_pipe u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  `CHK_IMPLY(a_busy_blocks, clk, rst_n, cfg.busy, !in_chan.ready, "input taken while derived config pending")
  `CHK_NEXT(a_write_recalc, clk, rst_n, cfg_wr, cfg.busy, "register write did not restart derivation")
  `CHK_IMPLY(a_bad_zeroed, clk, rst_n, out_chan.valid && (out_chan.out_of_range || out_chan.config_error), out_chan.source_index == '0 && out_chan.dest_index == '0 && !out_chan.is_padding, "flagged result carries indices")
  `CHK_IMPLY(a_pad_src, clk, rst_n, out_chan.valid && out_chan.is_padding, out_chan.source_index == '0, "padding result with nonzero source")

endmodule
